FILE: hdl/fwlc_pkg.sv
package fwlc_pkg;

  localparam int unsigned MAX_SECTOR_BYTES = 65536;
  localparam int unsigned MIN_SECTOR_BYTES = 16;
  localparam int unsigned WORD_BITS        = 32;
  localparam int unsigned MAX_RES          = 7;
  localparam int unsigned RES_CNT_W        = $clog2(MAX_RES + 1);
  localparam int unsigned SIZE_W           = $clog2(MAX_SECTOR_BYTES + 1);
  localparam int unsigned BASE_W           = 16;

  localparam logic [WORD_BITS-1:0] HEADER_MARK  = 32'h5242_5300;
  localparam logic [WORD_BITS-1:0] ALL_ONES     = '1;
  localparam logic [SIZE_W-1:0]    HEADER_BYTES = SIZE_W'(8);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_READ  = 2'd1,
    OP_INCR  = 2'd2,
    OP_WDONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_WRITE = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [WORD_BITS-1:0] addr;
    logic [WORD_BITS-1:0] wdata;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  // sector geometry derived from the config registers
  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic [WORD_BITS-1:0] start0;
    logic [WORD_BITS-1:0] start1;
    logic [WORD_BITS-1:0] erase0;
    logic [WORD_BITS-1:0] erase1;
  } geom_t;

  typedef struct packed {
    logic                 load;
    logic [RES_CNT_W-1:0] n;
    logic [WORD_BITS-1:0] count;
    logic                 ready;
  } obuf_ctl_t;

endpackage

FILE: hdl/fwlc_cfg.sv
module fwlc_cfg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [2:0]             cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready,
  output fwlc_pkg::geom_t        geom_o
);
  import fwlc_pkg::*;

  logic [BASE_W-1:0] base_r;
  logic [SIZE_W-1:0] ssize_r;
  logic              wr;
  reg_idx_t          idx;
  logic [SIZE_W-1:0] size_c;
  logic [32:0]       prod;
  logic [32:0]       sum1;
  geom_t             geom_r;
  geom_t             geom_nxt;

  assign cfg_pready = 1'b1;
  assign wr  = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx = reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      ssize_r <= SIZE_W'(4096);
    end else if (wr) begin
      unique case (idx)
        REG_BASE: base_r  <= cfg_pwdata[BASE_W-1:0];
        REG_SIZE: ssize_r <= cfg_pwdata[SIZE_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE: cfg_prdata = {{(32-BASE_W){1'b0}}, base_r};
      REG_SIZE: cfg_prdata = {{(32-SIZE_W){1'b0}}, ssize_r};
      default:  cfg_prdata = '0;
    endcase
  end

  // clamp to the legal range, then round down to whole words
  always_comb begin
    if (ssize_r < SIZE_W'(MIN_SECTOR_BYTES)) begin
      size_c = SIZE_W'(MIN_SECTOR_BYTES);
    end else if (ssize_r > SIZE_W'(MAX_SECTOR_BYTES)) begin
      size_c = SIZE_W'(MAX_SECTOR_BYTES);
    end else begin
      size_c = ssize_r;
    end
    size_c = size_c & ~SIZE_W'(3);
  end

  assign prod = 33'(base_r) * 33'(size_c);
  assign sum1 = prod + 33'(size_c);

  always_comb begin
    geom_nxt.size   = size_c;
    geom_nxt.start0 = prod[31:0];
    geom_nxt.start1 = sum1[31:0];
    geom_nxt.erase0 = 32'(base_r);
    // second sector wraps to address zero only when the sum carries out
    geom_nxt.erase1 = sum1[32] ? '0 : 32'(17'(base_r) + 17'd1);
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom_o = geom_r;

endmodule

FILE: hdl/fwlc_core.sv
module fwlc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_tuser,   // [1:0] opcode
  input  logic [39:0]          in_tdata,   // [31:0] read_word, [32] op_ok
  input  fwlc_pkg::geom_t      geom_i,
  input  logic                 obuf_free_i,
  output fwlc_pkg::obuf_ctl_t  ctl_o,
  output fwlc_pkg::res_list_t  list_o
);
  import fwlc_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HDR  = 4'b0010,
    PH_SCAN = 4'b0100,
    PH_RDY  = 4'b1000
  } phase_t;

  logic                 ivld_r;
  op_t                  iop_r;
  logic [WORD_BITS-1:0] iword_r;
  logic                 iok_r;
  logic                 go;
  logic                 in_acc;

  phase_t               phase_r, phase_nxt;
  logic [1:0]           hstep_r, hstep_nxt;
  logic [1:0]           hgood_r, hgood_nxt;
  logic [WORD_BITS-1:0] hsv0_r, hsv0_nxt;
  logic [WORD_BITS-1:0] hsv1_r, hsv1_nxt;
  logic                 act_r, act_nxt;
  logic [SIZE_W-1:0]    woff_r, woff_nxt;
  logic [WORD_BITS-1:0] cur_r, cur_nxt;
  logic [WORD_BITS-1:0] cnt_r, cnt_nxt;
  logic                 await_r, await_nxt;

  res_list_t            list;
  logic [RES_CNT_W-1:0] n;
  logic [SIZE_W:0]      woff_p4;
  logic                 at_end;

  function automatic res_t mk(cmd_t c, logic [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] d);
    res_t r;
    r.cmd   = c;
    r.addr  = a;
    r.wdata = d;
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] half_addr(geom_t g, logic h);
    return h ? g.start1 : g.start0;
  endfunction

  function automatic logic [WORD_BITS-1:0] erase_addr(geom_t g, logic h);
    return h ? g.erase1 : g.erase0;
  endfunction

  function automatic logic [5:0] zeros(logic [WORD_BITS-1:0] w);
    logic [5:0] z;
    z = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      z = z + 6'(~w[i]);
    end
    return z;
  endfunction

  assign go        = ivld_r & obuf_free_i;
  assign in_tready = ~ivld_r | go;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= 1'b0;
    end else if (in_acc) begin
      ivld_r <= 1'b1;
    end else if (go) begin
      ivld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      iop_r   <= op_t'(in_tuser);
      iword_r <= in_tdata[31:0];
      iok_r   <= in_tdata[32];
    end
  end

  assign woff_p4 = {1'b0, woff_r} + (SIZE_W+1)'(4);
  assign at_end  = woff_p4 >= {1'b0, geom_i.size};

  always_comb begin
    phase_nxt = phase_r;
    hstep_nxt = hstep_r;
    hgood_nxt = hgood_r;
    hsv0_nxt  = hsv0_r;
    hsv1_nxt  = hsv1_r;
    act_nxt   = act_r;
    woff_nxt  = woff_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    await_nxt = await_r;
    list      = '0;
    n         = RES_CNT_W'(1);

    if (go) begin
      unique case (iop_r)
        OP_START: begin
          phase_nxt = PH_HDR;
          hstep_nxt = '0;
          hgood_nxt = '0;
          hsv0_nxt  = '0;
          hsv1_nxt  = '0;
          cnt_nxt   = '0;
          await_nxt = 1'b0;
          woff_nxt  = '0;
          cur_nxt   = '0;
          list[0]   = mk(CMD_READ, geom_i.start0, '0);
        end

        OP_READ: begin
          unique case (phase_r)
            PH_HDR: begin
              if (!iok_r) begin
                phase_nxt = PH_IDLE;
              end else begin
                unique case (hstep_r)
                  2'd0: hgood_nxt[0] = hgood_r[0] | (iword_r == HEADER_MARK);
                  2'd1: hsv0_nxt     = iword_r;
                  2'd2: hgood_nxt[1] = hgood_r[1] | (iword_r == HEADER_MARK);
                  2'd3: hsv1_nxt     = iword_r;
                  default: ;
                endcase
                if (hstep_r != 2'd3) begin
                  hstep_nxt = hstep_r + 2'd1;
                  list[0] = mk(CMD_READ,
                               half_addr(geom_i, hstep_nxt[1]) + {29'b0, hstep_nxt[0], 2'b00},
                               '0);
                end else begin
                  if (hgood_nxt != 2'b11) begin
                    // headers not both marked: wipe both sectors, both restart at zero
                    hsv0_nxt = '0;
                    hsv1_nxt = '0;
                  end
                  act_nxt   = (hsv0_nxt > hsv1_nxt) ? 1'b0 : 1'b1;
                  cnt_nxt   = act_nxt ? hsv1_nxt : hsv0_nxt;
                  woff_nxt  = HEADER_BYTES;
                  cur_nxt   = ALL_ONES;
                  phase_nxt = PH_SCAN;
                  if (hgood_nxt != 2'b11) begin
                    list[0] = mk(CMD_ERASE, erase_addr(geom_i, 1'b0), '0);
                    list[1] = mk(CMD_WRITE, geom_i.start0, HEADER_MARK);
                    list[2] = mk(CMD_WRITE, geom_i.start0 + 32'd4, '0);
                    list[3] = mk(CMD_ERASE, erase_addr(geom_i, 1'b1), '0);
                    list[4] = mk(CMD_WRITE, geom_i.start1, HEADER_MARK);
                    list[5] = mk(CMD_WRITE, geom_i.start1 + 32'd4, '0);
                    list[6] = mk(CMD_READ,
                                 half_addr(geom_i, act_nxt) + 32'(HEADER_BYTES), '0);
                    n = RES_CNT_W'(7);
                  end else begin
                    list[0] = mk(CMD_READ,
                                 half_addr(geom_i, act_nxt) + 32'(HEADER_BYTES), '0);
                  end
                end
              end
            end

            PH_SCAN: begin
              if (!iok_r) begin
                phase_nxt = PH_IDLE;
              end else if (iword_r == ALL_ONES) begin
                // first blank word: step back to the last used one, if there is one
                if (woff_r > HEADER_BYTES) begin
                  woff_nxt = woff_r - SIZE_W'(4);
                end else begin
                  cur_nxt = ALL_ONES;
                end
                phase_nxt = PH_RDY;
              end else begin
                cnt_nxt = cnt_r + 32'(zeros(iword_r));
                cur_nxt = iword_r;
                if (at_end) begin
                  phase_nxt = PH_RDY;
                end else begin
                  woff_nxt = woff_p4[SIZE_W-1:0];
                  list[0]  = mk(CMD_READ,
                                half_addr(geom_i, act_r) + 32'(woff_p4[SIZE_W-1:0]), '0);
                end
              end
            end

            default: ;
          endcase
        end

        OP_INCR: begin
          if (phase_r == PH_RDY && !await_r) begin
            await_nxt = 1'b1;
            if (cur_r != '0) begin
              cur_nxt = cur_r & (cur_r - 32'd1);
              list[0] = mk(CMD_WRITE, half_addr(geom_i, act_r) + 32'(woff_r), cur_nxt);
            end else begin
              cur_nxt = ALL_ONES - 32'd1;
              if (at_end) begin
                // sector full: open the other one with the running count
                act_nxt  = ~act_r;
                woff_nxt = HEADER_BYTES;
                list[0]  = mk(CMD_ERASE, erase_addr(geom_i, act_nxt), '0);
                list[1]  = mk(CMD_WRITE, half_addr(geom_i, act_nxt), HEADER_MARK);
                list[2]  = mk(CMD_WRITE, half_addr(geom_i, act_nxt) + 32'd4, cnt_r);
                list[3]  = mk(CMD_WRITE,
                              half_addr(geom_i, act_nxt) + 32'(HEADER_BYTES), cur_nxt);
                n = RES_CNT_W'(4);
              end else begin
                woff_nxt = woff_p4[SIZE_W-1:0];
                list[0]  = mk(CMD_WRITE,
                              half_addr(geom_i, act_r) + 32'(woff_p4[SIZE_W-1:0]), cur_nxt);
              end
            end
          end
        end

        OP_WDONE: begin
          if (await_r) begin
            await_nxt = 1'b0;
            if (iok_r && phase_r == PH_RDY) begin
              cnt_nxt = cnt_r + 32'd1;
            end
          end
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hstep_r <= '0;
      hgood_r <= '0;
      hsv0_r  <= '0;
      hsv1_r  <= '0;
      act_r   <= 1'b0;
      woff_r  <= '0;
      cur_r   <= '0;
      cnt_r   <= '0;
      await_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      hstep_r <= hstep_nxt;
      hgood_r <= hgood_nxt;
      hsv0_r  <= hsv0_nxt;
      hsv1_r  <= hsv1_nxt;
      act_r   <= act_nxt;
      woff_r  <= woff_nxt;
      cur_r   <= cur_nxt;
      cnt_r   <= cnt_nxt;
      await_r <= await_nxt;
    end
  end

  assign ctl_o.load  = go;
  assign ctl_o.n     = n;
  assign ctl_o.ready = (phase_nxt == PH_RDY);
  assign ctl_o.count = (phase_nxt == PH_RDY) ? cnt_nxt : '0;
  assign list_o      = list;

`ifndef NO_ASSERTIONS
  a_ack_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    await_r |-> (phase_r == PH_RDY))
    else $error("write acknowledge pending outside ready phase");

  a_offset_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SCAN || phase_r == PH_RDY) |->
      (woff_r >= HEADER_BYTES && woff_r[1:0] == 2'b00))
    else $error("tally word offset misaligned or inside header");
`endif

endmodule

FILE: hdl/fwlc_obuf.sv
module fwlc_obuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fwlc_pkg::obuf_ctl_t  ctl_i,
  input  fwlc_pkg::res_list_t  list_i,
  output logic                 free_o,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [103:0]         out_tdata,  // [31:0] flash_address, [63:32] write_word,
                                           // [95:64] count_value, [96] ready_res
  output logic [1:0]           out_tuser,  // [1:0] command
  output logic                 out_tlast
);
  import fwlc_pkg::*;

  res_list_t            ent_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic [WORD_BITS-1:0] cv_r;
  logic                 rdy_r;
  logic                 pop;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid & out_tready;
  // free when empty or when the final entry leaves this cycle
  assign free_o     = (cnt_r == '0) || (cnt_r == RES_CNT_W'(1) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl_i.load) begin
      cnt_r <= ctl_i.n;
    end else if (pop) begin
      cnt_r <= cnt_r - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      ent_r <= list_i;
      cv_r  <= ctl_i.count;
      rdy_r <= ctl_i.ready;
    end else if (pop) begin
      ent_r <= {res_t'('0), ent_r[MAX_RES-1:1]};
    end
  end

  assign out_tdata = {7'b0, rdy_r, cv_r, ent_r[0].wdata, ent_r[0].addr};
  assign out_tuser = ent_r[0].cmd;
  assign out_tlast = (cnt_r == RES_CNT_W'(1));

`ifndef NO_ASSERTIONS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.load |-> free_o)
    else $error("result list loaded over undelivered results");

  a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.load |=> (cnt_r != '0))
    else $error("input transaction produced no result");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RES_CNT_W'(MAX_RES))
    else $error("result count beyond list depth");
`endif

endmodule

FILE: hdl/flash_wear_leveled_counter_unit.sv
// Wear-leveled flash event counter. The block drives an external flash controller through
// its result stream (read, erase and write commands) and takes read data, increment events
// and write completions on its input stream; the count sits in tally words of two
// alternating sectors and is restored from flash after a start transaction. Each input
// transaction yields one to seven result transactions, the last one flagged by tlast, and
// every result carries the count (zero while not restored) and the restored flag.
// An input transaction is held in the input register until the result buffer is free,
// and its results are registered in the result buffer before they are offered; the result
// port moves one transaction per cycle while out_tready is high, and a list holds up to
// seven for a restore that rewrites both headers. Single-result items flow back to back;
// while a longer list drains, one more input waits in the input register and the next one
// is taken in the cycle the last result of the list leaves. Register writes reach sector
// addressing through the config registers and then the registered geometry.
module flash_wear_leveled_counter_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // [31:0] read_word, [32] op_ok
  input  logic [1:0]   in_tuser,   // [1:0] opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [31:0] flash_address, [63:32] write_word,
                                   // [95:64] count_value, [96] ready_res
  output logic [1:0]   out_tuser,  // [1:0] command
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import fwlc_pkg::*;

  geom_t     geom;
  obuf_ctl_t ctl;
  res_list_t list;
  logic      obuf_free;

  fwlc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .geom_o      (geom)
  );

  fwlc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .geom_i      (geom),
    .obuf_free_i (obuf_free),
    .ctl_o       (ctl),
    .list_o      (list)
  );

  fwlc_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl),
    .list_i     (list),
    .free_o     (obuf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
